>>> src/pcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_pkg
// Types, codes and helpers for the phasing column cost block.
// ----------------------------------------------------------------------------
package pcc_pkg;

    localparam int ACC_W = 13;           // cost accumulator, wraps mod 2^13
    localparam int CST_W = ACC_W + 1;    // sum of two accumulators
    localparam int DIF_W = CST_W + 2;    // signed difference of two costs
    localparam int OUT_W = 13;           // min_cost and quality ports
    localparam int ADDR_W = 4;           // APB address
    localparam int DATA_W = 32;          // APB data

    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    // register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_PHASABLE = 2'd0;
    localparam logic [1:0] REG_ALLOWED  = 2'd1;
    localparam logic [1:0] REG_COUNT    = 2'd2;

    // entry allele types
    localparam logic [1:0] AT_ALLELE1 = 2'd0;
    localparam logic [1:0] AT_ALLELE2 = 2'd1;

    // reported allele codes
    localparam logic [1:0] AL_EQUAL = 2'd2;

    typedef enum logic [1:0] {
        FN_LOAD  = 2'd0,
        FN_SET   = 2'd1,
        FN_FLIP  = 2'd2,
        FN_QUERY = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLIP,
        ST_SUM,
        ST_PICK,
        ST_OUT
    } t_state;

    // one candidate assignment
    typedef struct packed {
        logic             vld;
        logic [CST_W-1:0] cost;
        logic [1:0]       idx;
    } t_cand;

    // smaller of two candidates, the later one wins a tie
    function automatic t_cand later_min(t_cand a, t_cand b);
        if (b.vld && (!a.vld || b.cost <= a.cost)) begin
            return b;
        end
        return a;
    endfunction

    // |a - b| with a missing cost taken as -1, saturated
    function automatic logic [OUT_W-1:0] abs_diff_sat(t_cand a, t_cand b);
        logic signed [DIF_W-1:0] va;
        logic signed [DIF_W-1:0] vb;
        logic signed [DIF_W-1:0] d;
        logic [DIF_W-1:0]        m;
        va = a.vld ? signed'({2'b00, a.cost}) : '1;
        vb = b.vld ? signed'({2'b00, b.cost}) : '1;
        d  = va - vb;
        m  = (d < 0) ? DIF_W'(-d) : DIF_W'(d);
        if (m > DIF_W'(OUT_MAX)) begin
            return OUT_MAX;
        end
        return m[OUT_W-1:0];
    endfunction

endpackage

>>> src/phasing_column_cost.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phasing_column_cost
// Per-column MEC cost: entry store, 2x2 cost accumulators, best assignment.
// ----------------------------------------------------------------------------
// From accept to o_valid, a load or query passes the sum, pick and out states;
// a flip first passes the flip state, a set first walks the live entries
// (one entry-store read per cycle). One item at a time: the next item is
// taken the cycle after the result is registered.
// Synchronous active-low reset clears config, side mask and accumulators;
// the entry store is not cleared.
module phasing_column_cost
    import pcc_pkg::*;
#(
    parameter int MAX_READS  = 32,
    parameter int SCORE_BITS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_func,
    input  logic [4:0]        i_entry_index,
    input  logic [1:0]        i_allele_type,
    input  logic [7:0]        i_phred_score,
    input  logic [31:0]       i_partition_mask,

    output logic              o_valid,
    input  logic              i_stall,
    output logic [OUT_W-1:0]  o_min_cost,
    output logic [1:0]        o_hap0_allele,
    output logic [1:0]        o_hap1_allele,
    output logic [OUT_W-1:0]  o_quality,
    output logic              o_conflict,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int IDX_W = (MAX_READS > 1) ? $clog2(MAX_READS) : 1;
    localparam int CNT_W = $clog2(MAX_READS + 1);
    localparam int ENT_W = SCORE_BITS + 2;
    localparam logic [5:0] MAX_CNT = 6'(MAX_READS);

    // config
    logic       r_phasable;
    logic [3:0] r_allowed;
    logic [5:0] r_entry_count;

    // control
    t_state r_state, n_state;
    logic   in_acc;
    logic   mem_we;
    logic   rd_issue;
    logic   acc_clr;
    logic   side_ld;
    logic   side_flip;
    logic   out_ld;
    logic   idx_ok;
    logic   flip_ok;
    logic [5:0]       cnt_sat;
    logic [CNT_W-1:0] live_cnt;
    logic [IDX_W-1:0] mem_ra;

    // storage
    logic [ENT_W-1:0]     mem [MAX_READS];
    logic [ENT_W-1:0]     r_rd_data;
    logic [IDX_W-1:0]     r_rd_idx;
    logic [CNT_W-1:0]     r_addr;
    logic [MAX_READS-1:0] r_side;
    logic [ACC_W-1:0]     r_acc [4];

    // report pipeline
    logic [CST_W-1:0] r_cost [4];
    t_cand            r_per00, r_per01, r_per10, r_per11, r_best;
    t_cand            cand [4];

    logic [OUT_W-1:0] r_o_min_cost;
    logic [1:0]       r_o_hap0;
    logic [1:0]       r_o_hap1;
    logic [OUT_W-1:0] r_o_quality;
    logic             r_o_conflict;
    logic             r_o_valid;

    // entry decode
    logic [1:0]       e_type;
    logic             e_col_ok;
    logic             e_col;
    logic             e_part;
    logic [ACC_W-1:0] e_score;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phasable    <= 1'b0;
            r_allowed     <= '0;
            r_entry_count <= '0;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                REG_PHASABLE: r_phasable    <= pwdata[0];
                REG_ALLOWED:  r_allowed     <= pwdata[3:0];
                REG_COUNT:    r_entry_count <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_PHASABLE: prdata = DATA_W'(r_phasable);
            REG_ALLOWED:  prdata = DATA_W'(r_allowed);
            REG_COUNT:    prdata = DATA_W'(r_entry_count);
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // control
    // ------------------------------------------------------------------
    assign cnt_sat  = (r_entry_count > MAX_CNT) ? MAX_CNT : r_entry_count;
    assign live_cnt = cnt_sat[CNT_W-1:0];
    assign idx_ok   = {1'b0, i_entry_index} < MAX_CNT;
    assign flip_ok  = {1'b0, i_entry_index} < cnt_sat;
    assign in_acc   = i_valid && !o_stall;
    assign o_stall  = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        mem_we    = 1'b0;
        rd_issue  = 1'b0;
        mem_ra    = '0;
        acc_clr   = 1'b0;
        side_ld   = 1'b0;
        side_flip = 1'b0;
        out_ld    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_SUM;
                    case (t_func'(i_func))
                        FN_LOAD: begin
                            mem_we = idx_ok;
                        end
                        FN_SET: begin
                            if (r_phasable) begin
                                side_ld = 1'b1;
                                acc_clr = 1'b1;
                                if (live_cnt != '0) begin
                                    rd_issue = 1'b1;
                                    n_state  = ST_WALK;
                                end
                            end
                        end
                        FN_FLIP: begin
                            if (r_phasable && flip_ok) begin
                                side_flip = 1'b1;
                                rd_issue  = 1'b1;
                                mem_ra    = i_entry_index[IDX_W-1:0];
                                n_state   = ST_FLIP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_WALK: begin
                mem_ra   = r_addr[IDX_W-1:0];
                rd_issue = (r_addr < live_cnt);
                if (!rd_issue) begin
                    n_state = ST_SUM;
                end
            end
            ST_FLIP: n_state = ST_SUM;
            ST_SUM:  n_state = ST_PICK;
            ST_PICK: n_state = ST_OUT;
            ST_OUT: begin
                if (!r_o_valid || !i_stall) begin
                    out_ld  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // entry store
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[i_entry_index[IDX_W-1:0]] <=
                {SCORE_BITS'(i_phred_score), i_allele_type};
        end
        r_rd_data <= mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (rd_issue) begin
            r_rd_idx <= mem_ra;
        end
        if (r_state == ST_IDLE) begin
            r_addr <= CNT_W'(1);
        end else if (rd_issue) begin
            r_addr <= r_addr + CNT_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // side mask and accumulators
    // ------------------------------------------------------------------
    assign e_type   = r_rd_data[1:0];
    assign e_col_ok = (e_type == AT_ALLELE1) || (e_type == AT_ALLELE2);
    assign e_col    = (e_type == AT_ALLELE1);
    assign e_part   = r_side[r_rd_idx];
    assign e_score  = ACC_W'(r_rd_data[ENT_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= '0;
        end else if (side_ld) begin
            r_side <= i_partition_mask[MAX_READS-1:0];
        end else if (side_flip) begin
            r_side[i_entry_index[IDX_W-1:0]] <= ~r_side[i_entry_index[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || acc_clr) begin
            for (int k = 0; k < 4; k++) begin
                r_acc[k] <= '0;
            end
        end else if (e_col_ok) begin
            if (r_state == ST_WALK) begin
                r_acc[{e_part, e_col}] <= r_acc[{e_part, e_col}] + e_score;
            end else if (r_state == ST_FLIP) begin
                r_acc[{~e_part, e_col}] <= r_acc[{~e_part, e_col}] - e_score;
                r_acc[{e_part, e_col}]  <= r_acc[{e_part, e_col}] + e_score;
            end
        end
    end

    // ------------------------------------------------------------------
    // report: sums, minimum, output
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SUM) begin
            for (int a = 0; a < 4; a++) begin
                r_cost[a] <= {1'b0, r_acc[a % 2]} + {1'b0, r_acc[2 + a / 2]};
            end
        end
    end

    always_comb begin
        for (int a = 0; a < 4; a++) begin
            cand[a].vld  = r_allowed[a];
            cand[a].cost = r_cost[a];
            cand[a].idx  = 2'(a);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_PICK) begin
            r_per00 <= later_min(cand[0], cand[2]);
            r_per01 <= later_min(cand[1], cand[3]);
            r_per10 <= later_min(cand[0], cand[1]);
            r_per11 <= later_min(cand[2], cand[3]);
            r_best  <= later_min(later_min(cand[0], cand[1]),
                                 later_min(cand[2], cand[3]));
        end
    end

    logic [OUT_W-1:0] q0, q1;
    assign q0 = abs_diff_sat(r_per00, r_per01);
    assign q1 = abs_diff_sat(r_per10, r_per11);

    always_ff @(posedge i_clk) begin
        if (out_ld) begin
            r_o_min_cost  <= '0;
            r_o_hap0      <= AL_EQUAL;
            r_o_hap1      <= AL_EQUAL;
            r_o_quality   <= '0;
            r_o_conflict  <= 1'b0;
            if (r_phasable) begin
                if (!r_best.vld) begin
                    r_o_conflict <= 1'b1;
                end else begin
                    r_o_min_cost  <= (r_best.cost > CST_W'(OUT_MAX)) ?
                                     OUT_MAX : r_best.cost[OUT_W-1:0];
                    r_o_hap0      <= (q0 == '0) ? AL_EQUAL : {1'b0, r_best.idx[0]};
                    r_o_hap1      <= (q1 == '0) ? AL_EQUAL : {1'b0, r_best.idx[1]};
                    r_o_quality   <= q1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_ld) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_min_cost    = r_o_min_cost;
    assign o_hap0_allele = r_o_hap0;
    assign o_hap1_allele = r_o_hap1;
    assign o_quality     = r_o_quality;
    assign o_conflict    = r_o_conflict;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != ST_IDLE))
        else $error("accepted item did not start");

    a_set_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_func == FN_SET && r_phasable) |=>
        (r_acc[0] == '0 && r_acc[1] == '0 && r_acc[2] == '0 && r_acc[3] == '0))
        else $error("accumulators not cleared on set");

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (CNT_W'(r_rd_idx) < live_cnt))
        else $error("walk read beyond live count");

    a_out_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && (!r_o_valid || !i_stall)) |=>
        (o_valid && r_state == ST_IDLE))
        else $error("result not registered");

endmodule
